/* hdl/cipm_pkg.sv */
// Package for the case-insensitive pattern matcher: sizes, register indexes
// and the letter folding function. Depends on nothing.
`default_nettype none

package cipm_pkg;

   localparam int PATTERN_MAX       = 32;
   localparam int OFFSET_BITS       = 32;

   localparam int PATTERN_WORDS     = 4;
   localparam int WORD_BITS         = 64;
   localparam int STORED_BYTES      = PATTERN_WORDS * WORD_BITS / 8;
   localparam int STORED_IDX_BITS   = $clog2(STORED_BYTES);
   localparam int CFG_LEN_BITS      = 6;
   localparam int LEN_BITS          = $clog2(PATTERN_MAX + 1);
   localparam int SEL_BITS          = (LEN_BITS > STORED_IDX_BITS + 1) ?
                                      LEN_BITS : STORED_IDX_BITS + 1;
   localparam int MATCH_OFFSET_BITS = 32;
   localparam int SCORE_BITS        = 6;
   localparam int WIDE_BITS         = OFFSET_BITS + MATCH_OFFSET_BITS;
   localparam int CSR_INDEX_BITS    = 3;

   localparam logic [CSR_INDEX_BITS-1:0] REG_PATTERN_WORD_0 = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_PATTERN_WORD_1 = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_PATTERN_WORD_2 = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_PATTERN_WORD_3 = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_PATTERN_LENGTH = 3'd4;

   typedef logic [7:0] byte_type;

   function automatic byte_type fold_case(input byte_type c);
      byte_type r;
      r = c;
      if (c >= 8'h41 && c <= 8'h5A) begin
         r = c + 8'h20;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

/* hdl/cipm_req_if.sv */
// Input byte channel of the pattern matcher.
// Depends on cipm_pkg for the byte type.
`default_nettype none

interface cipm_req_if;
   logic                valid;
   logic                ready;
   cipm_pkg::byte_type  data_byte;
   logic                chunk_start;

   modport source (output valid, output data_byte, output chunk_start, input ready);
   modport sink   (input valid, input data_byte, input chunk_start, output ready);
endinterface

`default_nettype wire

/* hdl/cipm_rsp_if.sv */
// Match result channel of the pattern matcher.
// Depends on cipm_pkg for the field widths.
`default_nettype none

interface cipm_rsp_if;
   logic                                    valid;
   logic                                    ready;
   logic [cipm_pkg::MATCH_OFFSET_BITS-1:0]  match_offset;
   logic [cipm_pkg::SCORE_BITS-1:0]         match_score;

   modport source (output valid, output match_offset, output match_score, input ready);
   modport sink   (input valid, input match_offset, input match_score, output ready);
endinterface

`default_nettype wire

/* hdl/cipm_csr_if.sv */
// Register write channel of the pattern matcher.
// Depends on cipm_pkg for the index and data widths.
`default_nettype none

interface cipm_csr_if;
   logic                                  valid;
   logic                                  ready;
   logic [cipm_pkg::CSR_INDEX_BITS-1:0]   reg_index;
   logic [cipm_pkg::WORD_BITS-1:0]        write_data;

   modport source (output valid, output reg_index, output write_data, input ready);
   modport sink   (input valid, input reg_index, input write_data, output ready);
endinterface

`default_nettype wire

/* hdl/case_insensitive_pattern_matcher.sv */
// Top level of the case-insensitive pattern matcher.
// Depends on cipm_pkg and the interfaces cipm_req_if, cipm_rsp_if, cipm_csr_if.
//
//   Channel    Direction  Carries
//   req_chan   in         data_byte, chunk_start
//   rsp_chan   out        match_offset, match_score (zero or one per byte)
//   csr_chan   in         reg_index, write_data
//
// One byte is accepted every cycle while the result channel does not stall; a
// byte's result is registered in the result register behind the window compare,
// which loads from the input register.
// Reset is synchronous and clears the pattern registers, counters and valid flags.
// A stalled result holds in the result register; the input register still
// takes a byte, and further bytes wait until the result is taken.
`default_nettype none

module case_insensitive_pattern_matcher (
   input  wire logic    clock,
   input  wire logic    reset,
   cipm_req_if.sink     req_chan,
   cipm_rsp_if.source   rsp_chan,
   cipm_csr_if.sink     csr_chan
);

   localparam int PM = cipm_pkg::PATTERN_MAX;

   logic [cipm_pkg::WORD_BITS-1:0]    pattern_word_ff [cipm_pkg::PATTERN_WORDS];
   logic [cipm_pkg::CFG_LEN_BITS-1:0] pattern_length_ff;
   cipm_pkg::byte_type                pattern_bytes [cipm_pkg::STORED_BYTES];

   cipm_pkg::byte_type                aligned_ff [PM];
   cipm_pkg::byte_type                aligned_in [PM];
   logic [PM-1:0]                     mask_ff, mask_in;
   logic [cipm_pkg::LEN_BITS-1:0]     len_eff_ff, len_eff_in;

   logic                              s1_valid_ff;
   cipm_pkg::byte_type                s1_byte_ff;
   logic                              s1_start_ff;

   cipm_pkg::byte_type                window_ff [PM];
   cipm_pkg::byte_type                window_in [PM];
   logic [cipm_pkg::LEN_BITS-1:0]     count_ff, count_in, count_base;
   logic [cipm_pkg::OFFSET_BITS-1:0]  position_ff, position_in, position_base;

   logic                                    rsp_valid_ff;
   logic [cipm_pkg::MATCH_OFFSET_BITS-1:0]  rsp_offset_ff, rsp_offset_in;
   logic [cipm_pkg::SCORE_BITS-1:0]         rsp_score_ff;

   logic                              out_free, process, hit;
   logic [PM-1:0]                     lane_ok;
   logic [cipm_pkg::OFFSET_BITS-1:0]  start_offset;
   logic [cipm_pkg::WIDE_BITS-1:0]    wide_offset;

   // Register writes.
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int w = 0; w < cipm_pkg::PATTERN_WORDS; w++) begin
            pattern_word_ff[w] <= '0;
         end
         pattern_length_ff <= '0;
      end else if (csr_chan.valid) begin
         case (csr_chan.reg_index)
            cipm_pkg::REG_PATTERN_WORD_0: pattern_word_ff[0] <= csr_chan.write_data;
            cipm_pkg::REG_PATTERN_WORD_1: pattern_word_ff[1] <= csr_chan.write_data;
            cipm_pkg::REG_PATTERN_WORD_2: pattern_word_ff[2] <= csr_chan.write_data;
            cipm_pkg::REG_PATTERN_WORD_3: pattern_word_ff[3] <= csr_chan.write_data;
            cipm_pkg::REG_PATTERN_LENGTH:
               pattern_length_ff <= csr_chan.write_data[cipm_pkg::CFG_LEN_BITS-1:0];
            default: ;
         endcase
      end
   end

   // The pattern is reversed and aligned to the window in a register, so that
   // the per-byte compare is lane against lane.
   always_comb begin
      logic [cipm_pkg::SEL_BITS-1:0] sel;
      for (int b = 0; b < cipm_pkg::STORED_BYTES; b++) begin
         pattern_bytes[b] = pattern_word_ff[b / 8][(b % 8) * 8 +: 8];
      end
      if (int'(pattern_length_ff) > PM) begin
         len_eff_in = cipm_pkg::LEN_BITS'(PM);
      end else begin
         len_eff_in = cipm_pkg::LEN_BITS'(pattern_length_ff);
      end
      for (int k = 0; k < PM; k++) begin
         sel = cipm_pkg::SEL_BITS'(len_eff_in) - cipm_pkg::SEL_BITS'(k + 1);
         mask_in[k] = (int'(len_eff_in) > k);
         if (mask_in[k] && sel < cipm_pkg::SEL_BITS'(cipm_pkg::STORED_BYTES)) begin
            aligned_in[k] = cipm_pkg::fold_case(
                               pattern_bytes[sel[cipm_pkg::STORED_IDX_BITS-1:0]]);
         end else begin
            aligned_in[k] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_eff_ff <= '0;
         mask_ff    <= '0;
      end else begin
         len_eff_ff <= len_eff_in;
         mask_ff    <= mask_in;
      end
      aligned_ff <= aligned_in;
   end

   // Handshake.
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign process        = s1_valid_ff && out_free;
   assign req_chan.ready = !s1_valid_ff || out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         s1_valid_ff <= req_chan.valid;
      end
      if (req_chan.valid && req_chan.ready) begin
         s1_byte_ff  <= req_chan.data_byte;
         s1_start_ff <= req_chan.chunk_start;
      end
   end

   // Window compare.
   always_comb begin
      window_in[0] = cipm_pkg::fold_case(s1_byte_ff);
      for (int k = 1; k < PM; k++) begin
         window_in[k] = window_ff[k - 1];
      end
      for (int k = 0; k < PM; k++) begin
         lane_ok[k] = !mask_ff[k] || (window_in[k] == aligned_ff[k]);
      end

      count_base    = s1_start_ff ? '0 : count_ff;
      position_base = s1_start_ff ? '0 : position_ff;
      count_in      = (int'(count_base) < PM) ? count_base + 1'b1 : count_base;
      position_in   = (position_base != '1) ? position_base + 1'b1 : position_base;

      hit = (len_eff_ff != '0) && (count_in >= len_eff_ff) && (&lane_ok);

      start_offset = position_base - cipm_pkg::OFFSET_BITS'(len_eff_ff)
                     + cipm_pkg::OFFSET_BITS'(1);
      wide_offset  = cipm_pkg::WIDE_BITS'(start_offset);
      if (wide_offset > cipm_pkg::WIDE_BITS'({cipm_pkg::MATCH_OFFSET_BITS{1'b1}})) begin
         rsp_offset_in = '1;
      end else begin
         rsp_offset_in = wide_offset[cipm_pkg::MATCH_OFFSET_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         position_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (process) begin
         count_ff     <= count_in;
         position_ff  <= position_in;
         rsp_valid_ff <= hit;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (process) begin
         window_ff <= window_in;
      end
      if (process && hit) begin
         rsp_offset_ff <= rsp_offset_in;
         rsp_score_ff  <= cipm_pkg::SCORE_BITS'(len_eff_ff);
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.match_offset = rsp_offset_ff;
   assign rsp_chan.match_score  = rsp_score_ff;

`ifndef SYNTHESIS
   a_hit_reaches_output: assert property (@(posedge clock) disable iff (reset)
      process && hit |=> rsp_valid_ff)
      else $error("Match was not presented on the result channel.");

   a_score_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_score_ff != '0)
      else $error("Result carries a zero score.");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      int'(count_ff) <= PM)
      else $error("Byte count exceeded the pattern capacity.");

   a_held_input_byte: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !out_free |=> s1_valid_ff && $stable(s1_byte_ff))
      else $error("Waiting input byte was lost or overwritten.");
`endif

endmodule

`default_nettype wire

/* test/cipm_match_checker.sv */
// Checker for the case-insensitive pattern matcher: watches the register, byte and
// match channels, predicts every match and compares it field by field.
// Depends on cipm_pkg and the interfaces cipm_req_if, cipm_rsp_if and cipm_csr_if.

module cipm_match_checker
   import cipm_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   cipm_req_if       req_mon,
   cipm_rsp_if       rsp_mon,
   cipm_csr_if       csr_mon,
   output int        error_count,
   output int        matches_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [MATCH_OFFSET_BITS-1:0] offset;
      logic [SCORE_BITS-1:0]        score;
   } match_type;

   logic [WORD_BITS-1:0]    pattern_words [PATTERN_WORDS];
   logic [CFG_LEN_BITS-1:0] pattern_len;
   byte_type                window [PATTERN_MAX];
   int unsigned             run_length;
   logic [OFFSET_BITS-1:0]  next_offset;
   match_type               expected_matches [$];
   int                      failures = 0;

   function automatic byte_type lower(input byte_type b);
      return (b inside {[8'h41:8'h5A]}) ? (b | 8'h20) : b;
   endfunction

   function automatic byte_type pattern_at(input int unsigned i);
      if (i >= STORED_BYTES) begin
         return '0;
      end
      return lower(pattern_words[i / (WORD_BITS / 8)][(i % (WORD_BITS / 8)) * 8 +: 8]);
   endfunction

   task automatic take_byte(input byte_type raw, input logic restart);
      byte_type               c;
      logic [OFFSET_BITS-1:0] here;
      logic [OFFSET_BITS-1:0] first;
      int unsigned            span;
      bit                     hit;
      match_type              found;
      c = lower(raw);
      if (restart) begin
         run_length  = 0;
         next_offset = '0;
      end
      for (int k = PATTERN_MAX - 1; k > 0; k--) begin
         window[k] = window[k-1];
      end
      window[0] = c;
      here = next_offset;
      if (next_offset != '1) begin
         next_offset++;
      end
      if (run_length < PATTERN_MAX) begin
         run_length++;
      end
      span = (pattern_len > PATTERN_MAX) ? PATTERN_MAX : pattern_len;
      if (span == 0 || run_length < span) begin
         return;
      end
      hit = 1'b1;
      for (int k = 0; k < span; k++) begin
         if (window[k] != pattern_at(span - 1 - k)) begin
            hit = 1'b0;
         end
      end
      if (hit) begin
         first = here - OFFSET_BITS'(span - 1);
         if (first > {MATCH_OFFSET_BITS{1'b1}}) begin
            first = {MATCH_OFFSET_BITS{1'b1}};
         end
         found.offset = MATCH_OFFSET_BITS'(first);
         found.score  = SCORE_BITS'(span);
         expected_matches.push_back(found);
      end
   endtask

   task automatic compare_match(input logic [MATCH_OFFSET_BITS-1:0] offset,
                                input logic [SCORE_BITS-1:0] score);
      match_type want;
      if (expected_matches.size() == 0) begin
         failures++;
         $error("unexpected match transaction: match_offset %0d, match_score %0d",
                offset, score);
         return;
      end
      want = expected_matches.pop_front();
      if (offset !== want.offset) begin
         failures++;
         $error("match_offset: expected %0d, actual %0d", want.offset, offset);
      end
      if (score !== want.score) begin
         failures++;
         $error("match_score: expected %0d, actual %0d", want.score, score);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         foreach (pattern_words[w]) begin
            pattern_words[w] = '0;
         end
         foreach (window[k]) begin
            window[k] = '0;
         end
         pattern_len = '0;
         run_length  = 0;
         next_offset = '0;
         expected_matches.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            compare_match(rsp_mon.match_offset, rsp_mon.match_score);
         end
         if (csr_mon.valid && csr_mon.ready) begin
            case (csr_mon.reg_index)
               REG_PATTERN_WORD_0: pattern_words[0] = csr_mon.write_data;
               REG_PATTERN_WORD_1: pattern_words[1] = csr_mon.write_data;
               REG_PATTERN_WORD_2: pattern_words[2] = csr_mon.write_data;
               REG_PATTERN_WORD_3: pattern_words[3] = csr_mon.write_data;
               REG_PATTERN_LENGTH: pattern_len = csr_mon.write_data[CFG_LEN_BITS-1:0];
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready) begin
            take_byte(req_mon.data_byte, req_mon.chunk_start);
         end
      end
      error_count     <= failures;
      matches_pending <= expected_matches.size();
   end

endmodule

/* test/tb_top.sv */
// Top of the pattern matcher testbench: clock, reset, register set-up, byte
// stimulus with idling and back-pressure, and the verdict.
// Depends on cipm_pkg, the channel interfaces, the matcher and cipm_match_checker.

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import cipm_pkg::*;

   localparam int SETTLE_CYCLES = 8;
   localparam int LONG_HOLD     = 300;
   localparam int PHASE_ITEMS   = 110;
   localparam int PHASE_COUNT   = 10;
   localparam logic [CSR_INDEX_BITS-1:0] REG_FIRST_UNUSED = REG_PATTERN_LENGTH + 1;
   localparam logic [CFG_LEN_BITS-1:0] PHASE_LENGTHS [PHASE_COUNT] =
      '{1, 3, 32, 0, 63, 7, 33, 16, 2, 12};

   logic clock = 1'b0;
   logic reset;

   cipm_req_if req_chan ();
   cipm_rsp_if rsp_chan ();
   cipm_csr_if csr_chan ();

   int       error_count;
   int       matches_pending;
   int       sender_idle_pct    = 0;
   int       receiver_stall_pct = 0;
   int       hold_requests      = 0;
   byte_type phase_pattern [STORED_BYTES];
   byte_type byte_plan [$];

   case_insensitive_pattern_matcher dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   cipm_match_checker match_checker (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_chan),
      .rsp_mon         (rsp_chan),
      .csr_mon         (csr_chan),
      .error_count     (error_count),
      .matches_pending (matches_pending)
   );

   always #2 clock = ~clock;

   initial begin
      #2ms;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // The receiver stalls at random and serves each long hold-off that is requested.
   initial begin
      int holds_served;
      int hold_left;
      holds_served = 0;
      hold_left    = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left == 0 && holds_served != hold_requests) begin
            holds_served++;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= receiver_stall_pct);
         end
      end
   end

   function automatic byte_type vary_case(input byte_type b);
      if ((b inside {[8'h41:8'h5A], [8'h61:8'h7A]}) && $urandom_range(1) == 1) begin
         return b ^ 8'h20;
      end
      return b;
   endfunction

   function automatic byte_type pick_pattern_byte();
      case ($urandom_range(7))
         0: return 8'h61;
         1: return 8'h41;
         2: return 8'h62;
         3: return 8'h42;
         4: return 8'h00;
         5: return 8'hFF;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   task automatic set_idling(input int mode);
      case (mode)
         0: begin
            sender_idle_pct    = 0;
            receiver_stall_pct = 0;
         end
         1: begin
            sender_idle_pct    = 48;
            receiver_stall_pct = 0;
         end
         2: begin
            sender_idle_pct    = 0;
            receiver_stall_pct = 48;
         end
         default: begin
            sender_idle_pct    = 23;
            receiver_stall_pct = 23;
         end
      endcase
   endtask

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] index,
                            input logic [WORD_BITS-1:0] data);
      csr_chan.valid      <= 1'b1;
      csr_chan.reg_index  <= index;
      csr_chan.write_data <= data;
      @(posedge clock);
      while (!csr_chan.ready) begin
         @(posedge clock);
      end
   endtask

   task automatic load_pattern(input logic [CFG_LEN_BITS-1:0] len_value);
      logic [WORD_BITS-1:0] word;
      logic [WORD_BITS-1:0] len_word;
      for (int w = 0; w < PATTERN_WORDS; w++) begin
         for (int i = 0; i < WORD_BITS / 8; i++) begin
            word[i*8 +: 8] = phase_pattern[w * (WORD_BITS / 8) + i];
         end
         write_reg(CSR_INDEX_BITS'(REG_PATTERN_WORD_0 + w), word);
      end
      len_word = {$urandom(), $urandom()};
      len_word[CFG_LEN_BITS-1:0] = len_value;
      write_reg(REG_PATTERN_LENGTH, len_word);
      write_reg(CSR_INDEX_BITS'($urandom_range(2**CSR_INDEX_BITS - 1, REG_FIRST_UNUSED)),
                {$urandom(), $urandom()});
      csr_chan.valid <= 1'b0;
   endtask

   task automatic send_byte(input byte_type data, input logic restart);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.data_byte   <= data;
      req_chan.chunk_start <= restart;
      @(posedge clock);
      while (!req_chan.ready) begin
         @(posedge clock);
      end
   endtask

   task automatic settle();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (matches_pending != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic run_phase(input int items, input logic [CFG_LEN_BITS-1:0] len_value);
      int       span;
      int       kind;
      int       cut;
      int       sent;
      byte_type b;
      foreach (phase_pattern[i]) begin
         phase_pattern[i] = pick_pattern_byte();
      end
      load_pattern(len_value);
      span = (len_value == 0) ? 4 : ((len_value > PATTERN_MAX) ? PATTERN_MAX : len_value);
      byte_plan.delete();
      sent = 0;
      while (sent < items) begin
         if (byte_plan.size() == 0) begin
            kind = $urandom_range(99);
            if (kind < 55) begin
               for (int i = 0; i < span; i++) begin
                  byte_plan.push_back(vary_case(phase_pattern[i]));
               end
            end else if (kind < 70) begin
               cut = $urandom_range((span > 1) ? span - 1 : 1, 1);
               for (int i = 0; i < cut; i++) begin
                  byte_plan.push_back(vary_case(phase_pattern[i]));
               end
            end else if (kind < 85) begin
               cut = $urandom_range(span - 1);
               for (int i = 0; i < span; i++) begin
                  b = vary_case(phase_pattern[i]);
                  if (i == cut) begin
                     b ^= 8'h01 << $urandom_range(7);
                  end
                  byte_plan.push_back(b);
               end
            end else begin
               repeat ($urandom_range(4, 1)) byte_plan.push_back(8'($urandom_range(255)));
            end
         end
         send_byte(byte_plan.pop_front(), $urandom_range(99) < 4);
         sent++;
      end
      settle();
   endtask

   initial begin
      logic [8:0] directed [15];
      directed = '{9'h161, 9'h000, 9'h05A, 9'h041, 9'h000, 9'h07A,
                   9'h040, 9'h000, 9'h05B, 9'h060, 9'h000, 9'h07B,
                   9'h061, 9'h000, 9'h17A};
      reset                <= 1'b1;
      req_chan.valid       <= 1'b0;
      req_chan.data_byte   <= '0;
      req_chan.chunk_start <= 1'b0;
      csr_chan.valid       <= 1'b0;
      csr_chan.reg_index   <= REG_PATTERN_WORD_0;
      csr_chan.write_data  <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Out of reset the length is zero, so these bytes must not match.
      set_idling(0);
      send_byte(8'h00, 1'b1);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h41, 1'b0);
      settle();

      // Pattern "A", zero, "Z" with every other stored byte all ones; the stream
      // mixes cases, letter boundaries and a restart that leaves too few bytes.
      foreach (phase_pattern[i]) begin
         phase_pattern[i] = 8'hFF;
      end
      phase_pattern[0] = 8'h41;
      phase_pattern[1] = 8'h00;
      phase_pattern[2] = 8'h5A;
      load_pattern(3);
      foreach (directed[i]) begin
         send_byte(directed[i][7:0], directed[i][8]);
      end
      settle();

      for (int p = 0; p < PHASE_COUNT; p++) begin
         set_idling(p % 4);
         run_phase(PHASE_ITEMS, PHASE_LENGTHS[p]);
      end

      // Long receiver hold-off while every byte completes a one-letter match.
      set_idling(0);
      phase_pattern[0] = 8'h61;
      load_pattern(1);
      hold_requests++;
      repeat (60) send_byte(vary_case(8'h41), 1'b0);
      settle();

      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
